// ===== rtl/core/cfe_pkg.sv =====
package cfe_pkg;

    // Fixed widths of the sample, length and fraction fields.
    localparam int SAMPLE_BITS = 24;
    localparam int LENGTH_BITS = 20;
    localparam int FRAC_BITS   = 16;

    localparam int IDX_BITS  = LENGTH_BITS + 1;
    localparam int GAIN_BITS = FRAC_BITS + 1;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FADE_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CURVE_SELECT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BUFFER_LENGTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FADE_LENGTH    = 2'd3;

    // Curve codes.
    localparam logic [1:0] CURVE_LINEAR     = 2'd0;
    localparam logic [1:0] CURVE_SQUARE     = 2'd1;
    localparam logic [1:0] CURVE_INVERTED   = 2'd2;
    localparam logic [1:0] CURVE_SMOOTHSTEP = 2'd3;

    // Fade directions.
    localparam logic DIR_FADE_IN  = 1'b0;
    localparam logic DIR_FADE_OUT = 1'b1;

    // Unity gain and the largest buffer length.
    localparam logic [GAIN_BITS-1:0] ONE_GAIN = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [IDX_BITS-1:0]  LEN_MAX  = {1'b1, {LENGTH_BITS{1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          buffer_start;
        logic                          frame_end;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [GAIN_BITS-1:0]          fade_gain;
    } result_t;

    typedef struct packed {
        logic                fade_direction;
        logic [1:0]          curve_select;
        logic [IDX_BITS-1:0] buffer_length;
        logic [IDX_BITS-1:0] fade_length;
    } cfg_t;

    // A classified item on its way from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          in_fade;
        logic [IDX_BITS-1:0]           offset;
        logic [IDX_BITS-1:0]           flen;
    } work_t;

endpackage

// ===== rtl/core/cfe_regs.sv =====
module cfe_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cfe_pkg::IDX_BITS-1:0]      cfg_data,
    output cfe_pkg::cfg_t                     cfg
);
    import cfe_pkg::*;

    cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register file with the documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fade_direction <= DIR_FADE_IN;
            cfg_reg.curve_select   <= CURVE_LINEAR;
            cfg_reg.buffer_length  <= LEN_MAX;
            cfg_reg.fade_length    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FADE_DIRECTION: cfg_reg.fade_direction <= cfg_data[0];
                REG_CURVE_SELECT:   cfg_reg.curve_select   <= cfg_data[1:0];
                REG_BUFFER_LENGTH:  cfg_reg.buffer_length  <= cfg_data;
                REG_FADE_LENGTH:    cfg_reg.fade_length    <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/cfe_front.sv =====
module cfe_front (
    input  logic            clk,
    input  logic            rst_n,
    input  cfe_pkg::cfg_t   cfg,
    input  logic            item_valid,
    output logic            item_ready,
    input  cfe_pkg::item_t  item,
    output logic            push_valid,
    input  logic            push_ready,
    output cfe_pkg::work_t  push_data
);
    import cfe_pkg::*;

    localparam logic [IDX_BITS-1:0] IDX_ONES = {IDX_BITS{1'b1}};

    logic [IDX_BITS-1:0] frame_index_reg;
    logic [IDX_BITS-1:0] frame_index_next;
    logic [IDX_BITS-1:0] idx;
    logic [IDX_BITS-1:0] len;
    logic [IDX_BITS-1:0] flen;
    logic [IDX_BITS-1:0] start;
    logic                in_fade;
    logic [IDX_BITS-1:0] offset;
    logic                accept;

    assign item_ready = push_ready;
    assign push_valid = item_valid;
    assign accept     = item_valid && push_ready;

    // Frame index seen by this item.
    assign idx = item.buffer_start ? '0 : frame_index_reg;

    // Clamp the buffer length and resolve a whole-buffer fade.
    always_comb
    begin
        if (cfg.buffer_length == '0)
            len = IDX_BITS'(1);
        else if (cfg.buffer_length > LEN_MAX)
            len = LEN_MAX;
        else
            len = cfg.buffer_length;

        if ((cfg.fade_length == '0) || (cfg.fade_length > len))
            flen = len;
        else
            flen = cfg.fade_length;
    end

    assign start = len - flen;

    // Decide whether the frame lies in the fade region and where.
    always_comb
    begin
        if (cfg.fade_direction == DIR_FADE_IN)
        begin
            in_fade = (idx < flen);
            offset  = idx;
        end
        else
        begin
            in_fade = (idx >= start) && (idx < len);
            offset  = idx - start;
        end
    end

    assign push_data.sample  = item.sample_in;
    assign push_data.in_fade = in_fade;
    assign push_data.offset  = offset;
    assign push_data.flen    = flen;

    // The index moves on after a frame end and saturates at all ones.
    always_comb
    begin
        frame_index_next = frame_index_reg;
        if (accept)
        begin
            if (item.frame_end && (idx != IDX_ONES))
                frame_index_next = idx + IDX_BITS'(1);
            else
                frame_index_next = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_index_reg <= '0;
        else
            frame_index_reg <= frame_index_next;
    end

endmodule

// ===== rtl/core/cfe_queue.sv =====
module cfe_queue #(
    parameter int DEPTH = cfe_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  cfe_pkg::work_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output cfe_pkg::work_t  pop_data
);
    import cfe_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

    work_t               mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage for queued items.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Pointers wrap at the configured depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_BITS'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_BITS'(1);
        end
    end

endmodule

// ===== rtl/core/cfe_back.sv =====
module cfe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  cfe_pkg::cfg_t    cfg,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  cfe_pkg::work_t   pop_data,
    output logic             result_valid,
    input  logic             result_ready,
    output cfe_pkg::result_t result
);
    import cfe_pkg::*;

    localparam int CNT_BITS   = $clog2(FRAC_BITS);
    localparam int SQ_BITS    = 2 * GAIN_BITS;
    localparam int HI_BITS    = FRAC_BITS + 2;
    localparam int LO_BITS    = FRAC_BITS + HI_BITS;
    localparam int BLEND_BITS = 2 * HI_BITS;
    localparam int PROD_BITS  = SAMPLE_BITS + GAIN_BITS + 1;

    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(FRAC_BITS - 1);
    localparam logic [HI_BITS-1:0]  THREE_ONE = HI_BITS'(3) << FRAC_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_SHAPE  = 3'd2;
    localparam logic [2:0] S_CURVE  = 3'd3;
    localparam logic [2:0] S_SMOOTH = 3'd4;
    localparam logic [2:0] S_BLEND  = 3'd5;
    localparam logic [2:0] S_SCALE  = 3'd6;
    localparam logic [2:0] S_HOLD   = 3'd7;

    logic [2:0]                    state_reg, state_next;
    logic                          valid_reg, valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [IDX_BITS-1:0]           flen_reg, flen_next;
    logic [IDX_BITS-1:0]           rem_reg, rem_next;
    logic [FRAC_BITS-1:0]          quo_reg, quo_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic [GAIN_BITS-1:0]          base_reg, base_next;
    logic [HI_BITS-1:0]            t_reg, t_next;
    logic [SQ_BITS-1:0]            sq_reg, sq_next;
    logic [LO_BITS-1:0]            lo_reg, lo_next;
    logic [BLEND_BITS-1:0]         hi_reg, hi_next;
    logic [GAIN_BITS-1:0]          gain_reg, gain_next;
    result_t                       result_reg, result_next;

    logic [IDX_BITS:0]             rem2;
    logic [IDX_BITS:0]             rem_diff;
    logic [GAIN_BITS-1:0]          pos;
    logic [GAIN_BITS-1:0]          base_w;
    logic [GAIN_BITS-1:0]          other_w;
    logic [GAIN_BITS-1:0]          sq_op;
    logic [HI_BITS-1:0]            sq_hi;
    logic [FRAC_BITS-1:0]          sq_lo;
    logic [BLEND_BITS-1:0]         blend;
    logic signed [GAIN_BITS:0]     gain_s;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   prod_shr;

    assign result_valid = valid_reg;
    assign result       = result_reg;

    // One restoring division step per cycle.
    assign rem2     = {rem_reg, 1'b0};
    assign rem_diff = rem2 - {1'b0, flen_reg};

    // Rising and falling curve variables from the position.
    assign pos     = {1'b0, quo_reg};
    assign base_w  = (cfg.fade_direction == DIR_FADE_OUT) ? ONE_GAIN - pos : pos;
    assign other_w = (cfg.fade_direction == DIR_FADE_OUT) ? pos : ONE_GAIN - pos;
    assign sq_op   = (cfg.curve_select == CURVE_INVERTED) ? other_w : base_w;

    // Split the square so the smoothstep product is two narrow multiplies.
    assign sq_hi = sq_reg[SQ_BITS-1:FRAC_BITS];
    assign sq_lo = sq_reg[FRAC_BITS-1:0];
    assign blend = hi_reg + BLEND_BITS'(lo_reg >> FRAC_BITS);

    // Final scaling with an arithmetic shift.
    assign gain_s   = $signed({1'b0, gain_reg});
    assign prod     = sample_reg * gain_s;
    assign prod_shr = prod >>> FRAC_BITS;

    // Sequencer for one item at a time.
    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        sample_next = sample_reg;
        flen_next   = flen_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        t_next      = t_reg;
        sq_next     = sq_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        gain_next   = gain_reg;
        result_next = result_reg;
        pop_ready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    sample_next = pop_data.sample;
                    flen_next   = pop_data.flen;
                    rem_next    = pop_data.offset;
                    quo_next    = '0;
                    cnt_next    = '0;
                    if (pop_data.in_fade)
                        state_next = S_DIV;
                    else
                    begin
                        gain_next  = ONE_GAIN;
                        state_next = S_SCALE;
                    end
                end
            end
            S_DIV:
            begin
                if (rem2 >= {1'b0, flen_reg})
                begin
                    rem_next = rem_diff[IDX_BITS-1:0];
                    quo_next = {quo_reg[FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[IDX_BITS-1:0];
                    quo_next = {quo_reg[FRAC_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == LAST_STEP)
                    state_next = S_SHAPE;
            end
            S_SHAPE:
            begin
                base_next  = base_w;
                t_next     = THREE_ONE - {base_w, 1'b0};
                sq_next    = SQ_BITS'(sq_op) * SQ_BITS'(sq_op);
                state_next = S_CURVE;
            end
            S_CURVE:
            begin
                state_next = S_SCALE;
                case (cfg.curve_select)
                    CURVE_LINEAR:   gain_next = base_reg;
                    CURVE_SQUARE:   gain_next = sq_hi[GAIN_BITS-1:0];
                    CURVE_INVERTED: gain_next = ONE_GAIN - sq_hi[GAIN_BITS-1:0];
                    default:
                    begin
                        lo_next    = LO_BITS'(sq_lo) * LO_BITS'(t_reg);
                        state_next = S_SMOOTH;
                    end
                endcase
            end
            S_SMOOTH:
            begin
                hi_next    = BLEND_BITS'(sq_hi) * BLEND_BITS'(t_reg);
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                gain_next  = GAIN_BITS'(blend >> FRAC_BITS);
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                result_next.sample_out = prod_shr[SAMPLE_BITS-1:0];
                result_next.fade_gain  = gain_reg;
                valid_next             = 1'b1;
                state_next             = S_HOLD;
            end
            S_HOLD:
            begin
                if (result_ready)
                begin
                    valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                valid_next = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        flen_reg   <= flen_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        base_reg   <= base_next;
        t_reg      <= t_next;
        sq_reg     <= sq_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        gain_reg   <= gain_next;
        result_reg <= result_next;
    end

endmodule

// ===== rtl/core/curved_fade_envelope.sv =====
// A sample outside the fade region goes from the queue straight to scaling; inside the
// region the position is first formed by the FRAC_BITS steps of the one-bit-per-cycle
// restoring divider, then shaped by the curve, with smoothing steps for smoothstep.
// The back holds one item until its result is accepted before it takes the next;
// the queue absorbs QUEUE_DEPTH items while the back works.
// Reset: rst_n, asynchronous, active low, clears frame index, queue, sequencer; sets config reset values.
module curved_fade_envelope #(
    parameter int QUEUE_DEPTH = cfe_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  cfe_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output cfe_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cfe_pkg::IDX_BITS-1:0]      cfg_data
);
    import cfe_pkg::*;

    cfg_t  cfg;
    logic  push_valid;
    logic  push_ready;
    work_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    work_t pop_data;

    // Configuration registers.
    cfe_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Front: frame counting and fade region classification.
    cfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue between the front and the back.
    cfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: position, curve shaping and sample scaling.
    cfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== tb/tb_curved_fade_envelope.sv =====
`timescale 1ns / 1ps

module tb_curved_fade_envelope;

    import cfe_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Tracks the fade settings and frame position, and holds the samples still owed.
    class fade_scoreboard;
        logic                fade_dir;
        logic [1:0]          curve;
        logic [IDX_BITS-1:0] buf_len;
        logic [IDX_BITS-1:0] fade_len;
        logic [IDX_BITS-1:0] frame_idx;
        result_t             owed_samples[$];
        int unsigned         mismatches;
        int unsigned         checked;

        function new();
            fade_dir   = DIR_FADE_IN;
            curve      = CURVE_LINEAR;
            buf_len    = LEN_MAX;
            fade_len   = '0;
            frame_idx  = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] index, logic [IDX_BITS-1:0] data);
            case (index)
                REG_FADE_DIRECTION: fade_dir = data[0];
                REG_CURVE_SELECT:   curve    = data[1:0];
                REG_BUFFER_LENGTH:  buf_len  = data;
                REG_FADE_LENGTH:    fade_len = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_samples.size();
        endfunction

        // Works out the gain and scaled sample for one accepted item and moves the frame on.
        function void note_item(item_t it);
            logic [IDX_BITS-1:0] idx;
            logic [IDX_BITS-1:0] len;
            logic [IDX_BITS-1:0] flen;
            logic [IDX_BITS-1:0] start;
            logic [63:0]         pos;
            logic [63:0]         rising;
            logic [63:0]         falling;
            logic [63:0]         gain;
            logic signed [63:0]  smp;
            logic signed [63:0]  prod;
            logic signed [63:0]  scaled;
            result_t             exp_r;

            idx = it.buffer_start ? '0 : frame_idx;
            len = (buf_len == 0) ? IDX_BITS'(1) : buf_len;
            if (len > LEN_MAX)
                len = LEN_MAX;
            flen = (fade_len == 0 || fade_len > len) ? len : fade_len;
            start = (fade_dir == DIR_FADE_IN) ? '0 : len - flen;
            gain = 64'(ONE_GAIN);

            // Inside the fade region the position is shaped by the selected curve.
            if (idx >= start && idx < start + flen) begin
                pos = (64'(idx - start) << FRAC_BITS) / 64'(flen);
                rising  = (fade_dir == DIR_FADE_IN) ? pos : 64'(ONE_GAIN) - pos;
                falling = 64'(ONE_GAIN) - rising;
                case (curve)
                    CURVE_LINEAR:   gain = rising;
                    CURVE_SQUARE:   gain = (rising * rising) >> FRAC_BITS;
                    CURVE_INVERTED: gain = 64'(ONE_GAIN) - ((falling * falling) >> FRAC_BITS);
                    default:
                        gain = (rising * rising * (3 * 64'(ONE_GAIN) - 2 * rising))
                               >> (2 * FRAC_BITS);
                endcase
            end

            // Arithmetic shift gives the rounding toward minus infinity.
            smp = {{(64-SAMPLE_BITS){it.sample_in[SAMPLE_BITS-1]}}, it.sample_in};
            prod = smp * $signed(gain);
            scaled = prod >>> FRAC_BITS;
            exp_r.sample_out = scaled[SAMPLE_BITS-1:0];
            exp_r.fade_gain  = gain[GAIN_BITS-1:0];
            owed_samples.push_back(exp_r);

            if (it.frame_end && idx != {IDX_BITS{1'b1}})
                idx = idx + 1'b1;
            frame_idx = idx;
        endfunction

        // Compares one accepted result with the oldest owed sample.
        function void check_result(result_t got);
            result_t exp_r;
            checked++;
            if (owed_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result with nothing owed: sample_out %0d gain %0d",
                             got.sample_out, got.fade_gain);
                return;
            end
            exp_r = owed_samples.pop_front();
            if (got.sample_out !== exp_r.sample_out || got.fade_gain !== exp_r.fade_gain) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result %0d: sample_out exp %0d got %0d, gain exp %0d got %0d",
                             checked, exp_r.sample_out, got.sample_out,
                             exp_r.fade_gain, got.fade_gain);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_ready;
    item_t                   item_bus;
    logic                    result_valid;
    logic                    result_ready;
    result_t                 result_bus;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [IDX_BITS-1:0]     cfg_data;

    fade_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int settings_done;
    int quiet_cycles;
    logic [3:0] curves_seen;
    logic [1:0] dirs_seen;

    curved_fade_envelope dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The receiver stalls at random at each falling edge.
    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            board.check_result(result_bus);
    end

    // Watchdog on cycles without any accepted item, result or register write.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic item_t make_item(logic [SAMPLE_BITS-1:0] smp, logic first, logic last);
        item_t it;
        it.sample_in    = smp;
        it.buffer_start = first;
        it.frame_end    = last;
        return it;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_BITS'($urandom_range(0, 16)) - SAMPLE_BITS'(8);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Entered at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item_bus   <= it;
        do @(posedge clk); while (!item_ready);
        board.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    // Lets every owed sample come back, then writes all four registers.
    task automatic configure(input logic dir, input logic [1:0] crv,
                             input logic [IDX_BITS-1:0] blen, input logic [IDX_BITS-1:0] flen);
        logic [CFG_IDX_BITS-1:0] reg_ids [4];
        logic [IDX_BITS-1:0]     values [4];
        reg_ids[0] = REG_FADE_DIRECTION;
        reg_ids[1] = REG_CURVE_SELECT;
        reg_ids[2] = REG_BUFFER_LENGTH;
        reg_ids[3] = REG_FADE_LENGTH;
        values[0] = IDX_BITS'(dir);
        values[1] = IDX_BITS'(crv);
        values[2] = blen;
        values[3] = flen;
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        for (int r = 0; r < 4; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_ids[r];
            cfg_data  <= values[r];
            do @(posedge clk); while (!cfg_ready);
            board.write_reg(reg_ids[r], values[r]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_done++;
        curves_seen[crv] = 1'b1;
        dirs_seen[dir]   = 1'b1;
    endtask

    // One buffer of interleaved frames; a noisy buffer scatters the marks at random.
    task automatic send_buffer(input int frames, input int chans, input int noise_pct);
        item_t it;
        for (int f = 0; f < frames; f++) begin
            for (int c = 0; c < chans; c++) begin
                it = make_item(rand_sample(), f == 0 && c == 0, c == chans - 1);
                if ($urandom_range(0, 99) < noise_pct) begin
                    it.buffer_start = 1'($urandom_range(0, 1));
                    it.frame_end    = 1'($urandom_range(0, 1));
                end
                send_item(it);
            end
        end
    endtask

    task automatic directed_part();
        // Reset settings: whole-buffer linear fade-in, so gains start at zero.
        send_item(make_item(SAMPLE_MAX, 1'b1, 1'b1));
        send_item(make_item(SAMPLE_MIN, 1'b0, 1'b1));
        send_item(make_item('1, 1'b0, 1'b0));
        send_item(make_item(SAMPLE_BITS'(1), 1'b0, 1'b1));

        // Smoothstep over a short buffer, running two frames past its end.
        configure(DIR_FADE_IN, CURVE_SMOOTHSTEP, IDX_BITS'(4), '0);
        for (int f = 0; f < 6; f++)
            send_item(make_item(f[0] ? SAMPLE_MIN : SAMPLE_MAX, f == 0, 1'b1));

        // Zero buffer length counts as one frame; a longer fade covers it all.
        configure(DIR_FADE_OUT, CURVE_INVERTED, '0, IDX_BITS'(5));
        send_item(make_item(SAMPLE_MAX, 1'b1, 1'b1));
        send_item(make_item(SAMPLE_MIN, 1'b0, 1'b1));

        // An oversized buffer length saturates, leaving the start at unity gain.
        configure(DIR_FADE_OUT, CURVE_SQUARE, '1, IDX_BITS'(3));
        send_item(make_item(SAMPLE_MIN, 1'b1, 1'b1));
        send_item(make_item(SAMPLE_MAX, 1'b0, 1'b1));

        // Two-channel linear fade-out over the last two of three frames.
        configure(DIR_FADE_OUT, CURVE_LINEAR, IDX_BITS'(3), IDX_BITS'(2));
        for (int f = 0; f < 3; f++) begin
            send_item(make_item(SAMPLE_MAX, f == 0, 1'b0));
            send_item(make_item(SAMPLE_MIN, 1'b0, 1'b1));
        end
    endtask

    // Random settings, each followed by a few buffers.
    task automatic random_part(input int quota);
        int                  stop_at;
        int                  eff_len;
        int                  frames;
        logic [IDX_BITS-1:0] blen;
        logic [IDX_BITS-1:0] flen;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: blen = '0;
                1: blen = LEN_MAX;
                2: blen = $urandom_range(0, 1) ? '1 : IDX_BITS'($urandom);
                default: blen = IDX_BITS'($urandom_range(1, 24));
            endcase
            eff_len = (blen == 0) ? 1 : (blen > LEN_MAX) ? int'(LEN_MAX) : int'(blen);
            case ($urandom_range(0, 7))
                0: flen = '0;
                1: flen = IDX_BITS'($urandom);
                2: flen = IDX_BITS'(eff_len + $urandom_range(1, 3));
                default: flen = IDX_BITS'($urandom_range(1, eff_len));
            endcase
            configure(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), blen, flen);
            repeat ($urandom_range(1, 3)) begin
                frames = (eff_len > 24 ? 24 : eff_len) + int'($urandom_range(0, 3));
                send_buffer(frames, int'($urandom_range(1, 3)),
                            ($urandom_range(0, 3) == 0) ? 30 : 0);
            end
        end
    endtask

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item_bus      = '0;
        result_ready  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_FADE_DIRECTION;
        cfg_data      = '0;
        quiet_cycles  = 0;
        items_sent    = 0;
        settings_done = 0;
        curves_seen   = '0;
        dirs_seen     = '0;
        send_idle_pct = 15;
        recv_idle_pct = 58;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_part();
        random_part(350);
        send_idle_pct = 58;
        recv_idle_pct = 15;
        random_part(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_part(350);

        // Drain what is still owed, then give the block time to show anything extra.
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples under %0d register settings, %0d results checked.",
                 items_sent, settings_done, board.checked);
        $display("Curves exercised %b, directions %b, mismatches %0d.",
                 curves_seen, dirs_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
